// ----- hw/rtl/tile_map_quad_generator_unit_assert.svh -----
// ---------------------------------------------------------------------------
// tile map quad generator assertion macros
// clocked assertion helpers used by tmq_checker
// ---------------------------------------------------------------------------
`ifndef TILE_MAP_QUAD_GENERATOR_UNIT_ASSERT_SVH
`define TILE_MAP_QUAD_GENERATOR_UNIT_ASSERT_SVH

// assertion that is switched off while reset is high
`define TMQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion that also holds across reset
`define TMQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/tmq_pkg.sv -----
// ---------------------------------------------------------------------------
// tmq_pkg
// shared types, widths and helpers of the tile map quad generator
// ---------------------------------------------------------------------------
`default_nettype none

package tmq_pkg;

  localparam int unsigned MAX_MAP_DIM_DEF = 256;
  localparam int unsigned TILE_DIM_MAX    = 256;

  localparam int unsigned TILE_W     = 16;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned TEX_W      = 14;
  localparam int unsigned POS_W      = 17;
  localparam int unsigned UV_W       = 25;
  localparam int unsigned CORNER_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 14;

  localparam logic [DIM_W-1:0] MAP_COLUMNS_RST   = 9'd1;
  localparam logic [DIM_W-1:0] MAP_ROWS_RST      = 9'd1;
  localparam logic [DIM_W-1:0] TILE_WIDTH_RST    = 9'd16;
  localparam logic [DIM_W-1:0] TILE_HEIGHT_RST   = 9'd16;
  localparam logic [TEX_W-1:0] TEXTURE_WIDTH_RST = 14'd256;

  // divider: dividend bits consumed DIV_STEPS per cycle
  localparam int unsigned DIV_DVD_W  = TILE_W;
  localparam int unsigned DIV_DVS_W  = TEX_W;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = DIV_DVD_W / DIV_STEPS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_COLUMNS,
    REG_MAP_ROWS,
    REG_TILE_WIDTH,
    REG_TILE_HEIGHT,
    REG_TEXTURE_WIDTH
  } cfg_reg_t;

  typedef enum logic [CORNER_W-1:0] {
    CORNER_TL,
    CORNER_TR,
    CORNER_BR,
    CORNER_BL
  } corner_t;

  typedef enum logic [1:0] {
    FR_RATE,
    FR_RATE_WAIT,
    FR_IDLE,
    FR_TILE
  } front_state_t;

  typedef struct packed {
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [TEX_W-1:0] tex_w;
    logic             rate_dirty;
  } tmq_cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_DVD_W-1:0] dividend;
    logic [DIV_DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 valid;
    logic [DIV_DVD_W-1:0] quotient;
    logic [DIV_DVS_W-1:0] remainder;
  } div_rsp_t;

  function automatic int unsigned cnt_width(input int unsigned dim);
    return (dim > 2) ? $clog2(dim) : 1;
  endfunction

  // zero reads as one, anything above the limit saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned hi);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > hi) return DIM_W'(hi);
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tmq_tile_if.sv -----
// ---------------------------------------------------------------------------
// tmq_tile_if
// valid/ready channel carrying one tile number per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface tmq_tile_if import tmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TILE_W-1:0] tile_number;

  modport source(output valid, output tile_number, input ready);
  modport sink(input valid, input tile_number, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmq_vertex_if.sv -----
// ---------------------------------------------------------------------------
// tmq_vertex_if
// valid/ready channel carrying one quad corner vertex per transfer
// ---------------------------------------------------------------------------
`default_nettype none

interface tmq_vertex_if import tmq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CORNER_W-1:0] corner;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [UV_W-1:0]     tex_u;
  logic [UV_W-1:0]     tex_v;
  logic                last_corner;
  logic                map_done;

  modport source(output valid, output corner, output pos_x, output pos_y, output tex_u,
                 output tex_v, output last_corner, output map_done, input ready);
  modport sink(input valid, input corner, input pos_x, input pos_y, input tex_u,
               input tex_v, input last_corner, input map_done, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tmq_div.sv -----
// ---------------------------------------------------------------------------
// tmq_div
// iterative restoring divider, four quotient bits per cycle
// ---------------------------------------------------------------------------
`default_nettype none

module tmq_div import tmq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_DVS_W-1:0] rem;
  logic [DIV_DVS_W-1:0] rem_next;
  logic [DIV_DVS_W-1:0] dvs;
  logic [DIV_DVD_W-1:0] quo;
  logic [DIV_DVD_W-1:0] quo_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic                 done;

  always_comb begin : iterate
    logic [DIV_DVS_W:0]   trial;
    logic [DIV_DVS_W-1:0] r;
    logic [DIV_DVD_W-1:0] q;
    logic [DIV_DVS_W-1:0] d;
    // a start runs the first block of steps on the fresh operands
    if (req.start) begin
      r = '0;
      q = req.dividend;
      d = req.divisor;
    end else begin
      r = rem;
      q = quo;
      d = dvs;
    end
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r, q[DIV_DVD_W-1]};
      q     = {q[DIV_DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial = trial - {1'b0, d};
        q[0]  = 1'b1;
      end
      r = trial[DIV_DVS_W-1:0];
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (req.start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= DIV_CNT_W'(1);
    end else if (running) begin
      cnt <= cnt + DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start || running) begin
      rem <= rem_next;
      quo <= quo_next;
    end
    if (req.start) begin
      dvs <= req.divisor;
    end
  end

  assign rsp.valid     = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ----- hw/rtl/tmq_queue.sv -----
// ---------------------------------------------------------------------------
// tmq_queue
// short register queue between the tile front end and the vertex back end
// ---------------------------------------------------------------------------
`default_nettype none

module tmq_queue import tmq_pkg::*; #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmq_front.sv -----
// ---------------------------------------------------------------------------
// tmq_front
// takes tiles, tracks map position and splits tile numbers into texture cells
// ---------------------------------------------------------------------------
`default_nettype none

module tmq_front import tmq_pkg::*; #(
  parameter int unsigned MAX_MAP_DIM = MAX_MAP_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  tmq_cfg_t            cfg,
  tmq_tile_if.sink            tile_in,
  output div_req_t            div_req,
  input  div_rsp_t            div_rsp,
  output logic                push,
  output logic [2*cnt_width(MAX_MAP_DIM)+TEX_W+TILE_W:0] push_data,
  input  logic                q_full
);

  localparam int unsigned CNT_W = cnt_width(MAX_MAP_DIM);
  localparam int unsigned CMP_W = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

  front_state_t     state;
  front_state_t     state_next;
  logic             rate_stale;
  logic [TEX_W-1:0] per_row;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] pend_col;
  logic [CNT_W-1:0] pend_row;
  logic             pend_done;
  logic             accept;
  logic             last_row;
  logic             last_col;

  assign accept = tile_in.valid && tile_in.ready;

  // a counter at or past its last index counts as on the last index
  assign last_row = (CMP_W'(row) + CMP_W'(1)) >= CMP_W'(cfg.rows);
  assign last_col = (CMP_W'(col) + CMP_W'(1)) >= CMP_W'(cfg.cols);

  always_comb begin
    state_next = state;
    case (state)
      FR_RATE: begin
        state_next = FR_RATE_WAIT;
      end
      FR_RATE_WAIT: begin
        if (div_rsp.valid) begin
          state_next = rate_stale ? FR_RATE : FR_IDLE;
        end
      end
      FR_IDLE: begin
        if (rate_stale) begin
          state_next = FR_RATE;
        end else if (accept) begin
          state_next = FR_TILE;
        end
      end
      FR_TILE: begin
        if (push) begin
          state_next = accept ? FR_TILE : FR_IDLE;
        end
      end
      default: begin
        state_next = FR_RATE;
      end
    endcase
  end

  always_comb begin
    tile_in.ready = 1'b0;
    push          = 1'b0;
    case (state)
      FR_IDLE: begin
        tile_in.ready = !rate_stale;
      end
      FR_TILE: begin
        push          = div_rsp.valid && !q_full;
        tile_in.ready = !rate_stale && div_rsp.valid && !q_full;
      end
      default: begin
        tile_in.ready = 1'b0;
        push          = 1'b0;
      end
    endcase
    // shared divider: tiles per texture row, or tile number by tiles per row
    div_req.start    = (state == FR_RATE) || accept;
    div_req.dividend = (state == FR_RATE) ? DIV_DVD_W'(cfg.tex_w) : tile_in.tile_number;
    div_req.divisor  = (state == FR_RATE) ? DIV_DVS_W'(cfg.tw) : per_row;
  end

  assign push_data = {pend_col, pend_row, div_rsp.remainder, div_rsp.quotient, pend_done};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FR_RATE;
      rate_stale <= 1'b0;
      col        <= '0;
      row        <= '0;
    end else begin
      state <= state_next;
      if (cfg.rate_dirty) begin
        rate_stale <= 1'b1;
      end else if (state == FR_RATE) begin
        rate_stale <= 1'b0;
      end
      if (accept) begin
        if (last_row) begin
          row <= '0;
          col <= last_col ? '0 : col + CNT_W'(1);
        end else begin
          row <= row + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == FR_RATE_WAIT && div_rsp.valid) begin
      per_row <= (div_rsp.quotient == '0) ? TEX_W'(1) : div_rsp.quotient[TEX_W-1:0];
    end
    if (accept) begin
      pend_col  <= col;
      pend_row  <= row;
      pend_done <= last_row && last_col;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tmq_back.sv -----
// ---------------------------------------------------------------------------
// tmq_back
// scales a queued tile to pixels and sends its four corner vertices
// ---------------------------------------------------------------------------
`default_nettype none

module tmq_back import tmq_pkg::*; #(
  parameter int unsigned MAX_MAP_DIM = MAX_MAP_DIM_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  tmq_cfg_t     cfg,
  input  logic         q_valid,
  input  logic [2*cnt_width(MAX_MAP_DIM)+TEX_W+TILE_W:0] q_head,
  output logic         pop,
  tmq_vertex_if.source vertex_out
);

  localparam int unsigned CNT_W = cnt_width(MAX_MAP_DIM);

  logic [CNT_W-1:0]       e_col;
  logic [CNT_W-1:0]       e_row;
  logic [TEX_W-1:0]       e_tu;
  logic [TILE_W-1:0]      e_tv;
  logic                   e_done;
  logic [CNT_W+DIM_W-1:0] px;
  logic [CNT_W+DIM_W-1:0] py;
  logic [TEX_W+DIM_W-1:0] pu;
  logic [TILE_W+DIM_W-1:0] pv;

  logic                have;
  corner_t             corner;
  logic [CORNER_W-1:0] corner_inc;
  logic [POS_W-1:0]    bx;
  logic [POS_W-1:0]    by;
  logic [UV_W-1:0]     bu;
  logic [UV_W-1:0]     bv;
  logic                bdone;
  logic                dx;
  logic                dy;
  logic                out_load;

  logic                ov;
  logic [CORNER_W-1:0] o_corner;
  logic [POS_W-1:0]    o_x;
  logic [POS_W-1:0]    o_y;
  logic [UV_W-1:0]     o_u;
  logic [UV_W-1:0]     o_v;
  logic                o_last;
  logic                o_done;

  assign {e_col, e_row, e_tu, e_tv, e_done} = q_head;

  assign px = (CNT_W+DIM_W)'(e_col) * (CNT_W+DIM_W)'(cfg.tw);
  assign py = (CNT_W+DIM_W)'(e_row) * (CNT_W+DIM_W)'(cfg.th);
  assign pu = (TEX_W+DIM_W)'(e_tu) * (TEX_W+DIM_W)'(cfg.tw);
  assign pv = (TILE_W+DIM_W)'(e_tv) * (TILE_W+DIM_W)'(cfg.th);

  assign dx         = (corner == CORNER_TR) || (corner == CORNER_BR);
  assign dy         = (corner == CORNER_BR) || (corner == CORNER_BL);
  assign corner_inc = corner + CORNER_W'(1);

  // output register takes a corner whenever it is empty or being drained
  assign out_load = have && (!ov || vertex_out.ready);
  assign pop      = q_valid && (!have || (out_load && corner == CORNER_BL));

  always_ff @(posedge clk) begin
    if (rst) begin
      have   <= 1'b0;
      corner <= CORNER_TL;
      ov     <= 1'b0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (vertex_out.ready) begin
        ov <= 1'b0;
      end
      if (pop) begin
        have   <= 1'b1;
        corner <= CORNER_TL;
      end else if (out_load) begin
        corner <= corner_t'(corner_inc);
        if (corner == CORNER_BL) begin
          have <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bx    <= POS_W'(px);
      by    <= POS_W'(py);
      bu    <= UV_W'(pu);
      bv    <= UV_W'(pv);
      bdone <= e_done;
    end
    if (out_load) begin
      o_corner <= corner;
      o_x      <= bx + (dx ? POS_W'(cfg.tw) : '0);
      o_y      <= by + (dy ? POS_W'(cfg.th) : '0);
      o_u      <= bu + (dx ? UV_W'(cfg.tw) : '0);
      o_v      <= bv + (dy ? UV_W'(cfg.th) : '0);
      o_last   <= (corner == CORNER_BL);
      o_done   <= bdone && (corner == CORNER_BL);
    end
  end

  assign vertex_out.valid       = ov;
  assign vertex_out.corner      = o_corner;
  assign vertex_out.pos_x       = o_x;
  assign vertex_out.pos_y       = o_y;
  assign vertex_out.tex_u       = o_u;
  assign vertex_out.tex_v       = o_v;
  assign vertex_out.last_corner = o_last;
  assign vertex_out.map_done    = o_done;

endmodule

`default_nettype wire

// ----- hw/rtl/tile_map_quad_generator_unit.sv -----
// ---------------------------------------------------------------------------
// tile_map_quad_generator_unit
// turns a column-major stream of tile numbers into textured quad vertices
// ---------------------------------------------------------------------------
// The front divides one tile at a time: the shared divider splits each tile number
// into texture column and row at 4 quotient bits per cycle, and the next tile
// can be taken in the cycle its predecessor's result enters the queue. Each tile
// leaves as 4 vertices, one per cycle while the receiver is ready, from a
// registered output that keeps running while the front divides the next tile.
// After reset the front works out the tiles per texture row before it takes a
// tile; after a write to the tile width or texture width register it works it
// out again, first registering that the write happened.
`default_nettype none

module tile_map_quad_generator_unit import tmq_pkg::*; #(
  parameter int unsigned MAX_MAP_DIM = MAX_MAP_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tmq_tile_if.sink              tile_in,
  tmq_vertex_if.source          vertex_out
);

  localparam int unsigned CNT_W   = cnt_width(MAX_MAP_DIM);
  localparam int unsigned ENTRY_W = 2 * CNT_W + TEX_W + TILE_W + 1;

  logic [DIM_W-1:0]   map_columns;
  logic [DIM_W-1:0]   map_rows;
  logic [DIM_W-1:0]   tile_px_w;
  logic [DIM_W-1:0]   tile_px_h;
  logic [TEX_W-1:0]   texture_width;
  tmq_cfg_t           cfg;
  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic               push;
  logic [ENTRY_W-1:0] push_data;
  logic               q_full;
  logic               pop;
  logic               q_valid;
  logic [ENTRY_W-1:0] q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns   <= MAP_COLUMNS_RST;
      map_rows      <= MAP_ROWS_RST;
      tile_px_w     <= TILE_WIDTH_RST;
      tile_px_h     <= TILE_HEIGHT_RST;
      texture_width <= TEXTURE_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_COLUMNS:   map_columns   <= cfg_data[DIM_W-1:0];
        REG_MAP_ROWS:      map_rows      <= cfg_data[DIM_W-1:0];
        REG_TILE_WIDTH:    tile_px_w     <= cfg_data[DIM_W-1:0];
        REG_TILE_HEIGHT:   tile_px_h     <= cfg_data[DIM_W-1:0];
        REG_TEXTURE_WIDTH: texture_width <= cfg_data[TEX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.cols       = clamp_dim(map_columns, MAX_MAP_DIM);
    cfg.rows       = clamp_dim(map_rows, MAX_MAP_DIM);
    cfg.tw         = clamp_dim(tile_px_w, TILE_DIM_MAX);
    cfg.th         = clamp_dim(tile_px_h, TILE_DIM_MAX);
    cfg.tex_w      = texture_width;
    // tiles per texture row must be worked out again
    cfg.rate_dirty = cfg_we && ((cfg_index == REG_TILE_WIDTH) ||
                                (cfg_index == REG_TEXTURE_WIDTH));
  end

  tmq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  tmq_front #(
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .tile_in   (tile_in),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  tmq_queue #(
    .W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  tmq_back #(
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .vertex_out (vertex_out)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tmq_checker.sv -----
// ---------------------------------------------------------------------------
// tmq_checker
// port-level checks on the vertex stream of the quad generator
// ---------------------------------------------------------------------------
`default_nettype none

`include "tile_map_quad_generator_unit_assert.svh"

module tmq_checker import tmq_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [CORNER_W-1:0] out_corner,
  input wire logic [POS_W-1:0]    out_pos_x,
  input wire logic [POS_W-1:0]    out_pos_y,
  input wire logic [UV_W-1:0]     out_tex_u,
  input wire logic [UV_W-1:0]     out_tex_v,
  input wire logic                out_last,
  input wire logic                out_done
);

  logic [CORNER_W-1:0] exp_corner;
  logic                out_xfer;

  assign out_xfer = out_valid && out_ready;

  // corner expected on the next transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_corner <= CORNER_TL;
    end else if (out_xfer) begin
      exp_corner <= out_corner + CORNER_W'(1);
    end
  end

  `TMQ_ASSERT_ALWAYS(a_reset_clears_out, clk, rst |=> !out_valid, "vertex valid after reset")

  `TMQ_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_corner) && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_tex_u) && $stable(out_tex_v), "stalled vertex changed")

  `TMQ_ASSERT(a_corner_order, clk, rst, out_xfer |-> out_corner == exp_corner, "corner out of order")

  `TMQ_ASSERT(a_last_flags, clk, rst, out_valid |-> (out_last == (out_corner == CORNER_BL)) && (!out_done || out_last), "last corner or map end flag wrong")

endmodule

bind tile_map_quad_generator_unit tmq_checker u_tmq_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (vertex_out.valid),
  .out_ready  (vertex_out.ready),
  .out_corner (vertex_out.corner),
  .out_pos_x  (vertex_out.pos_x),
  .out_pos_y  (vertex_out.pos_y),
  .out_tex_u  (vertex_out.tex_u),
  .out_tex_v  (vertex_out.tex_v),
  .out_last   (vertex_out.last_corner),
  .out_done   (vertex_out.map_done)
);

`default_nettype wire
